// ----- sv/u2u8_pkg.sv -----
// Shared types and constants for the UTF-16 to UTF-8 stream encoder.
// No dependencies; imported by every module of the block.
package u2u8_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [15:0] MAX_BYTES_RESET = 16'd255;

    // Code unit range limits and UTF-8 marker bits
    localparam logic [15:0] LIMIT_1B  = 16'h0080;
    localparam logic [15:0] LIMIT_2B  = 16'h0800;
    localparam logic [7:0]  LEAD_2B   = 8'hC0;
    localparam logic [7:0]  LEAD_3B   = 8'hE0;
    localparam logic [7:0]  CONT_MARK = 8'h80;
    localparam logic [7:0]  CONT_MASK = 8'h3F;

    localparam logic [1:0] NBYTES_ONE   = 2'd1;
    localparam logic [1:0] NBYTES_TWO   = 2'd2;
    localparam logic [1:0] NBYTES_THREE = 2'd3;

    // One classified code unit: terminator flag, encoded bytes, how many are real
    typedef struct packed {
        logic       term;
        logic [1:0] nbytes;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } u2u8_entry_t;

    // Head of the queue as seen by the back end
    typedef struct packed {
        logic        valid;
        u2u8_entry_t entry;
    } u2u8_head_t;

endpackage

// ----- sv/u2u8_front.sv -----
// Front end: accepts code units and classifies them into UTF-8 byte groups.
// Depends on u2u8_pkg.
module u2u8_front (
    input  logic                  in_valid,
    input  logic [15:0]           code_unit,
    input  logic                  queue_full,
    output logic                  in_stall,
    output logic                  push,
    output u2u8_pkg::u2u8_entry_t push_entry
);
    import u2u8_pkg::*;

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        push_entry = '0;
        if (code_unit == 16'd0)
        begin
            push_entry.term   = 1'b1;
            push_entry.nbytes = NBYTES_ONE;
        end
        else if (code_unit < LIMIT_1B)
        begin
            push_entry.nbytes = NBYTES_ONE;
            push_entry.b0     = code_unit[7:0];
        end
        else if (code_unit < LIMIT_2B)
        begin
            push_entry.nbytes = NBYTES_TWO;
            push_entry.b0     = LEAD_2B | {3'b000, code_unit[10:6]};
            push_entry.b1     = CONT_MARK | (code_unit[7:0] & CONT_MASK);
        end
        else
        begin
            push_entry.nbytes = NBYTES_THREE;
            push_entry.b0     = LEAD_3B | {4'b0000, code_unit[15:12]};
            push_entry.b1     = CONT_MARK | (code_unit[13:6] & CONT_MASK);
            push_entry.b2     = CONT_MARK | (code_unit[7:0] & CONT_MASK);
        end
    end

endmodule

// ----- sv/u2u8_queue.sv -----
// Short queue of classified code units between front and back ends.
// Depends on u2u8_pkg.
module u2u8_queue #(
    parameter int DEPTH = u2u8_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  u2u8_pkg::u2u8_entry_t push_entry,
    input  logic                  pop,
    output logic                  full,
    output u2u8_pkg::u2u8_head_t  head
);
    import u2u8_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    u2u8_entry_t      mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    assign full        = (count_reg == CNT_W'(DEPTH));
    assign head.valid  = (count_reg != '0);
    assign head.entry  = mem[rd_ptr_reg];

endmodule

// ----- sv/u2u8_back.sv -----
// Back end: serializes queued byte groups, applies the byte limit, and
// holds the output register. Depends on u2u8_pkg.
module u2u8_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data,
    input  u2u8_pkg::u2u8_head_t head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_byte,
    output logic                 end_of_string,
    output logic [15:0]          string_length
);
    import u2u8_pkg::*;

    logic [15:0] max_bytes_reg;
    logic [15:0] count_reg, count_next;
    logic [1:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        eos_reg, eos_next;
    logic [15:0] len_reg, len_next;

    logic        out_free;
    logic        at_limit;
    logic        emit;
    logic [7:0]  cur_byte;

    assign out_free = !out_valid_reg || !out_stall;
    assign at_limit = (count_reg >= max_bytes_reg);

    always_comb
    begin
        case (idx_reg)
            2'd0:    cur_byte = head.entry.b0;
            2'd1:    cur_byte = head.entry.b1;
            default: cur_byte = head.entry.b2;
        endcase
    end

    always_comb
    begin
        pop            = 1'b0;
        emit           = 1'b0;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_byte_next  = out_byte_reg;
        eos_next       = eos_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (head.valid)
        begin
            if (head.entry.term)
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    pop           = 1'b1;
                    out_byte_next = 8'd0;
                    eos_next      = 1'b1;
                    len_next      = count_reg;
                    count_next    = '0;
                    idx_next      = '0;
                end
            end
            else if (at_limit)
            begin
                // drop the rest of this unit
                pop      = 1'b1;
                idx_next = '0;
            end
            else if (out_free)
            begin
                emit          = 1'b1;
                out_byte_next = cur_byte;
                eos_next      = 1'b0;
                len_next      = '0;
                count_next    = count_reg + 16'd1;
                if (idx_reg == head.entry.nbytes - 2'd1)
                begin
                    pop      = 1'b1;
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= MAX_BYTES_RESET;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_bytes_reg <= cfg_wr_data;
            end
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        eos_reg      <= eos_next;
        len_reg      <= len_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign end_of_string = eos_reg;
    assign string_length = len_reg;

`ifndef SYNTH
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head.valid && !head.entry.term |-> idx_reg < head.entry.nbytes)
        else $error("byte index past end of group");

    a_mid_group_head: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != 2'd0 |-> head.valid && !head.entry.term)
        else $error("mid-group with no data head");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        emit && !head.entry.term && !cfg_wr_en |=> count_reg == $past(count_reg) + 16'd1)
        else $error("byte count did not advance on emitted byte");

    a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit && head.entry.term |=> count_reg == 16'd0 && eos_reg && out_valid_reg)
        else $error("terminator did not clear count");
`endif

endmodule

// ----- sv/utf16_to_utf8_stream_encoder.sv -----
// Top level of the UTF-16 to UTF-8 stream encoder (BMP, unpaired surrogates).
// Depends on u2u8_pkg, u2u8_front, u2u8_queue and u2u8_back.
//
//   Channel  Direction  Handshake              Payload
//   input    in         in_valid / in_stall    code_unit[15:0]
//   output   out        out_valid / out_stall  out_byte, end_of_string, string_length
//   config   in         cfg_wr_en              cfg_wr_data[15:0] (max_bytes)
//
// Each code unit takes one back-end cycle per UTF-8 byte while the output is
// not stalled. A terminator emits a single zero byte, a unit dropped at the
// limit is popped without output, and a unit cut short drops the rest after
// its last byte. The single byte-wide back-end output register sets this rate;
// the front end accepts one transaction per cycle while the queue has room.
// Reset clears the byte count, the queue and the output valid, and loads
// max_bytes with 255. A stalled output holds its transaction; the queue lets
// the front keep accepting until it fills, then in_stall rises.
module utf16_to_utf8_stream_encoder #(
    parameter int QUEUE_DEPTH = u2u8_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] code_unit,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        end_of_string,
    output logic [15:0] string_length
);
    import u2u8_pkg::*;

    logic        push;
    u2u8_entry_t push_entry;
    logic        queue_full;
    logic        pop;
    u2u8_head_t  head;

    // Classify each incoming code unit into its byte group
    u2u8_front u_front (
        .in_valid   (in_valid),
        .code_unit  (code_unit),
        .queue_full (queue_full),
        .in_stall   (in_stall),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decouple acceptance from serialization
    u2u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .head       (head)
    );

    // Emit bytes, apply the limit, close strings
    u2u8_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .end_of_string (end_of_string),
        .string_length (string_length)
    );

endmodule
